/* src/circular_list_deque_remove_matching_unit_assert.svh */
// Assertion macros shared by the list unit's RTL files.
// Each macro samples on clk and is disabled while arst_n is low.
`ifndef CIRCULAR_LIST_DEQUE_REMOVE_MATCHING_UNIT_ASSERT_SVH
`define CIRCULAR_LIST_DEQUE_REMOVE_MATCHING_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// Antecedent implies consequent in the same cycle.
`define CLDRM_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("cldrm assertion failed");
// Antecedent implies consequent in the following cycle.
`define CLDRM_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("cldrm assertion failed");
`else
`define CLDRM_ASSERT_NOW(label, ante, cons)
`define CLDRM_ASSERT_NEXT(label, ante, cons)
`endif
`endif

/* src/cldrm_pkg.sv */
// Package for the list unit: widths, request and status codes, FSM states
// and the command/status structs between controller and datapath. No dependencies.
package cldrm_pkg;

	localparam int unsigned CAPACITY_DEF = 16;
	localparam int unsigned DATA_W       = 32;
	localparam int unsigned COUNT_W      = 5;

	typedef enum logic [1:0] {
		REQ_APPEND = 2'd0,
		REQ_INSERT = 2'd1,
		REQ_REMOVE = 2'd2,
		REQ_DUMP   = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_EMPTY = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DUMP,
		ST_RESP
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;
		logic scan_step;
		logic dump_emit;
		logic resp;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		req_t new_req;
		logic empty;
		logic idx_last;
		logic out_free;
	} stat_t;

endpackage

/* src/cldrm_req_if.sv */
// Request channel: valid/ready handshake carrying one request word.
// Depends on cldrm_pkg.
interface cldrm_req_if;
	logic                                   valid;
	logic                                   ready;
	cldrm_pkg::req_t                        req_type;
	logic signed [cldrm_pkg::DATA_W-1:0]    item_value;

	modport source (output valid, output req_type, output item_value, input ready);
	modport sink (input valid, input req_type, input item_value, output ready);
endinterface

/* src/cldrm_rsp_if.sv */
// Result channel: valid/ready handshake carrying one result word.
// Depends on cldrm_pkg.
interface cldrm_rsp_if;
	logic                                   valid;
	logic                                   ready;
	cldrm_pkg::status_t                     status;
	logic signed [cldrm_pkg::DATA_W-1:0]    entry_value;
	logic [cldrm_pkg::COUNT_W-1:0]          entry_count;
	logic [cldrm_pkg::COUNT_W-1:0]          removed_count;
	logic                                   last;

	modport source (output valid, output status, output entry_value, output entry_count,
		output removed_count, output last, input ready);
	modport sink (input valid, input status, input entry_value, input entry_count,
		input removed_count, input last, output ready);
endinterface

/* src/cldrm_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module cldrm_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 16,
	localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* src/cldrm_ctrl.sv */
// Controller state machine of the list unit: sequences accept, removal scan,
// dump and single-result responses. Depends on cldrm_pkg and the assertion header.
`include "circular_list_deque_remove_matching_unit_assert.svh"

module cldrm_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	input  cldrm_pkg::stat_t st,
	output cldrm_pkg::cmd_t  cmd
);

	cldrm_pkg::state_t state_q;
	cldrm_pkg::state_t state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cldrm_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands.
	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		case (state_q)
			cldrm_pkg::ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.accept = 1'b1;
					if (st.new_req == cldrm_pkg::REQ_APPEND ||
						st.new_req == cldrm_pkg::REQ_INSERT || st.empty) begin
						state_d = cldrm_pkg::ST_RESP;
					end else if (st.new_req == cldrm_pkg::REQ_REMOVE) begin
						state_d = cldrm_pkg::ST_SCAN;
					end else begin
						state_d = cldrm_pkg::ST_DUMP;
					end
				end
			end
			cldrm_pkg::ST_SCAN: begin
				cmd.scan_step = 1'b1;
				if (st.idx_last) begin
					state_d = cldrm_pkg::ST_RESP;
				end
			end
			cldrm_pkg::ST_DUMP: begin
				if (st.out_free) begin
					cmd.dump_emit = 1'b1;
					if (st.idx_last) begin
						state_d = cldrm_pkg::ST_IDLE;
					end
				end
			end
			cldrm_pkg::ST_RESP: begin
				if (st.out_free) begin
					cmd.resp = 1'b1;
					state_d  = cldrm_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = cldrm_pkg::ST_IDLE;
			end
		endcase
	end

	// At most one command is issued per cycle.
	`CLDRM_ASSERT_NOW(a_cmd_onehot, 1'b1, $onehot0(cmd))
	// A dump never starts on an empty list.
	`CLDRM_ASSERT_NEXT(a_dump_nonempty, cmd.accept && st.empty,
		state_q == cldrm_pkg::ST_RESP)
	// A result is only loaded when the output register can take it.
	`CLDRM_ASSERT_NOW(a_load_free, cmd.dump_emit || cmd.resp, st.out_free)

endmodule

/* src/cldrm_dp.sv */
// Datapath of the list unit: ring pointers, counts, entry RAM and the result
// register. Depends on cldrm_pkg, cldrm_ram, cldrm_rsp_if and the assertion header.
`include "circular_list_deque_remove_matching_unit_assert.svh"

module cldrm_dp #(
	parameter int unsigned CAPACITY = cldrm_pkg::CAPACITY_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  cldrm_pkg::req_t                     req_type,
	input  logic signed [cldrm_pkg::DATA_W-1:0] item_value,
	input  cldrm_pkg::cmd_t                     cmd,
	output cldrm_pkg::stat_t                    st,
	cldrm_rsp_if.source                         rsp
);

	localparam int unsigned IDX_W = $clog2(CAPACITY);
	localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
	localparam int unsigned SUM_W = CNT_W + 1;
	localparam int unsigned EXT_W = CNT_W + cldrm_pkg::COUNT_W;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);
	localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);
	localparam logic [SUM_W-1:0] CAP_S = SUM_W'(CAPACITY);

	// Control state.
	logic [IDX_W-1:0]                 front_q;
	logic [CNT_W-1:0]                 held_q;
	logic [CNT_W-1:0]                 idx_q;
	logic [CNT_W-1:0]                 kept_q;
	logic [IDX_W-1:0]                 rd_ptr_q;
	logic [IDX_W-1:0]                 wr_ptr_q;
	logic                             out_valid_q;
	cldrm_pkg::req_t                  req_q;
	// Payload registers.
	logic [cldrm_pkg::DATA_W-1:0]     val_q;
	cldrm_pkg::status_t               status_q;
	logic [cldrm_pkg::DATA_W-1:0]     value_q;
	logic [cldrm_pkg::COUNT_W-1:0]    count_q;
	logic [cldrm_pkg::COUNT_W-1:0]    removed_q;
	logic                             last_q;

	logic [IDX_W-1:0]                 rd_next;
	logic [IDX_W-1:0]                 wr_next;
	logic [IDX_W-1:0]                 front_dec;
	logic [SUM_W-1:0]                 app_sum;
	logic [IDX_W-1:0]                 app_addr;
	logic [CNT_W-1:0]                 idx_inc;
	logic                             idx_last;
	logic                             is_ins;
	logic                             full;
	logic                             empty;
	logic                             keep;
	logic                             ins_ok;
	logic                             out_free;
	logic                             load;

	logic                             ram_we;
	logic [IDX_W-1:0]                 ram_waddr;
	logic [cldrm_pkg::DATA_W-1:0]     ram_wdata;
	logic                             ram_re;
	logic [IDX_W-1:0]                 ram_raddr;
	logic [cldrm_pkg::DATA_W-1:0]     ram_rdata;

	cldrm_pkg::status_t               status_d;
	logic [cldrm_pkg::DATA_W-1:0]     value_d;
	logic [CNT_W-1:0]                 count_d;
	logic [CNT_W-1:0]                 removed_d;
	logic                             last_d;
	logic [EXT_W-1:0]                 count_ext;
	logic [EXT_W-1:0]                 removed_ext;

	// Ring arithmetic: the append slot sum stays below twice the capacity.
	assign rd_next   = (rd_ptr_q == LAST_IDX) ? '0 : rd_ptr_q + 1'b1;
	assign wr_next   = (wr_ptr_q == LAST_IDX) ? '0 : wr_ptr_q + 1'b1;
	assign front_dec = (front_q == '0) ? LAST_IDX : front_q - 1'b1;
	assign app_sum   = SUM_W'(front_q) + SUM_W'(held_q);
	assign app_addr  = (app_sum >= CAP_S) ? IDX_W'(app_sum - CAP_S) : IDX_W'(app_sum);

	// Flags for the controller.
	assign idx_inc  = idx_q + CNT_W'(1);
	assign idx_last = (idx_inc == held_q);
	assign is_ins   = (req_q == cldrm_pkg::REQ_APPEND) || (req_q == cldrm_pkg::REQ_INSERT);
	assign full     = (held_q == CAP_C);
	assign empty    = (held_q == '0);
	assign keep     = (ram_rdata != val_q);
	assign ins_ok   = cmd.resp && is_ins && !full;
	assign out_free = !out_valid_q || rsp.ready;
	assign load     = cmd.dump_emit || cmd.resp;

	always_comb begin
		st          = '0;
		st.new_req  = req_type;
		st.empty    = empty;
		st.idx_last = idx_last;
		st.out_free = out_free;
	end

	// Entry RAM ports: reads walk the ring, writes compact or insert.
	assign ram_re    = cmd.accept || cmd.scan_step || cmd.dump_emit;
	assign ram_raddr = cmd.accept ? front_q : rd_next;
	assign ram_we    = (cmd.scan_step && keep) || ins_ok;
	assign ram_waddr = cmd.scan_step ? wr_ptr_q :
		((req_q == cldrm_pkg::REQ_APPEND) ? app_addr : front_dec);
	assign ram_wdata = cmd.scan_step ? ram_rdata : val_q;

	cldrm_ram #(
		.WIDTH(cldrm_pkg::DATA_W),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Ring pointers, counts and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q     <= '0;
			held_q      <= '0;
			idx_q       <= '0;
			kept_q      <= '0;
			rd_ptr_q    <= '0;
			wr_ptr_q    <= '0;
			req_q       <= cldrm_pkg::REQ_APPEND;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.accept) begin
				req_q    <= req_type;
				idx_q    <= '0;
				kept_q   <= '0;
				rd_ptr_q <= front_q;
				wr_ptr_q <= front_q;
			end
			if (cmd.scan_step) begin
				idx_q    <= idx_inc;
				rd_ptr_q <= rd_next;
				if (keep) begin
					wr_ptr_q <= wr_next;
					kept_q   <= kept_q + CNT_W'(1);
				end
			end
			if (cmd.dump_emit) begin
				idx_q    <= idx_inc;
				rd_ptr_q <= rd_next;
			end
			if (ins_ok) begin
				held_q <= held_q + CNT_W'(1);
				if (req_q == cldrm_pkg::REQ_INSERT) begin
					front_q <= front_dec;
				end
			end
			if (cmd.resp && req_q == cldrm_pkg::REQ_REMOVE && !empty) begin
				held_q <= kept_q;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result word selection.
	always_comb begin
		status_d  = cldrm_pkg::STAT_OK;
		value_d   = '0;
		count_d   = held_q;
		removed_d = '0;
		last_d    = 1'b1;
		if (cmd.dump_emit) begin
			value_d = ram_rdata;
			last_d  = idx_last;
		end else if (is_ins) begin
			if (full) begin
				status_d = cldrm_pkg::STAT_FULL;
			end else begin
				count_d = held_q + CNT_W'(1);
			end
		end else if (empty) begin
			status_d = cldrm_pkg::STAT_EMPTY;
			count_d  = '0;
		end else begin
			count_d   = kept_q;
			removed_d = held_q - kept_q;
		end
	end

	// Counts leave the block at the field width.
	assign count_ext   = {{cldrm_pkg::COUNT_W{1'b0}}, count_d};
	assign removed_ext = {{cldrm_pkg::COUNT_W{1'b0}}, removed_d};

	// Result payload register.
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			val_q <= item_value;
		end
		if (load) begin
			status_q  <= status_d;
			value_q   <= value_d;
			count_q   <= count_ext[cldrm_pkg::COUNT_W-1:0];
			removed_q <= removed_ext[cldrm_pkg::COUNT_W-1:0];
			last_q    <= last_d;
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.status        = status_q;
	assign rsp.entry_value   = value_q;
	assign rsp.entry_count   = count_q;
	assign rsp.removed_count = removed_q;
	assign rsp.last          = last_q;

	// The held count never exceeds the capacity.
	`CLDRM_ASSERT_NOW(a_held_bound, 1'b1, held_q <= CAP_C)
	// Survivors of a scan never outnumber the held entries.
	`CLDRM_ASSERT_NOW(a_kept_bound, 1'b1, kept_q <= held_q)
	// The front pointer stays inside the ring.
	`CLDRM_ASSERT_NOW(a_front_range, 1'b1, front_q <= LAST_IDX)
	// A completed removal leaves exactly the surviving entries.
	`CLDRM_ASSERT_NEXT(a_remove_count,
		cmd.resp && req_q == cldrm_pkg::REQ_REMOVE && !empty,
		held_q == $past(kept_q))

endmodule

/* src/circular_list_deque_remove_matching_unit.sv */
// Top level of the bounded ordered list unit.
// Depends on cldrm_pkg, cldrm_req_if, cldrm_rsp_if, cldrm_ctrl and cldrm_dp.
//
// Usage: requests arrive on the req channel (req_type, item_value) and results
// leave on the rsp channel, both valid/ready; a word moves when valid and ready
// are high at a rising clock edge. Append and insert-front give one result
// each. Remove-matching reads one held entry per cycle from the entry RAM
// while compacting survivors in place, and its single result follows the
// scan. A dump streams one word per cycle while the receiver takes them, front
// to back, with last on the final word. Removal and dump on an empty list give
// one empty-status word. A removal or dump occupies the block while the single
// RAM read port walks the ring. One request is in flight at a time; the next
// is accepted as soon as the previous result is loaded into the output
// register, even if that word still waits to be taken. When the receiver holds
// ready low the result stays put and a dump pauses. Reset empties the list at
// once; entry contents are not cleared and no clearing pass runs.
module circular_list_deque_remove_matching_unit #(
	parameter int unsigned CAPACITY = cldrm_pkg::CAPACITY_DEF
) (
	input logic         clk,
	input logic         arst_n,
	cldrm_req_if.sink   req,
	cldrm_rsp_if.source rsp
);

	cldrm_pkg::cmd_t  cmd;
	cldrm_pkg::stat_t st;

	cldrm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req.valid),
		.req_ready(req.ready),
		.st       (st),
		.cmd      (cmd)
	);

	cldrm_dp #(
		.CAPACITY(CAPACITY)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_type  (req.req_type),
		.item_value(req.item_value),
		.cmd       (cmd),
		.st        (st),
		.rsp       (rsp)
	);

endmodule

/* sim/circular_list_deque_remove_matching_unit_tb.sv */
// Self-checking testbench for the bounded ordered list unit: a directed script followed by
// biased random traffic, with every result word compared against a list predictor.
// Depends on cldrm_pkg, cldrm_req_if, cldrm_rsp_if and circular_list_deque_remove_matching_unit.
module circular_list_deque_remove_matching_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned CAPACITY     = cldrm_pkg::CAPACITY_DEF;
	localparam int unsigned RANDOM_ITEMS = 142;
	localparam int unsigned CYCLE_LIMIT  = 400000;
	localparam int unsigned SCRIPT_LEN   = 24;

	// Receiver stall modes.
	localparam int unsigned STALL_NONE   = 0;
	localparam int unsigned STALL_LIGHT  = 1;
	localparam int unsigned STALL_HEAVY  = 2;
	localparam int unsigned STALL_TOGGLE = 3;

	// One result word as the block presents it.
	typedef struct packed {
		cldrm_pkg::status_t                  status;
		logic signed [cldrm_pkg::DATA_W-1:0] entry_value;
		logic [cldrm_pkg::COUNT_W-1:0]       entry_count;
		logic [cldrm_pkg::COUNT_W-1:0]       removed_count;
		logic                                last;
	} rsp_word_t;

	// One row of the directed script. Rows marked fixed carry their single result word
	// (entry value 0, nothing removed, last set); the others are left to the predictor.
	typedef struct {
		cldrm_pkg::req_t                     kind;
		logic signed [cldrm_pkg::DATA_W-1:0] value;
		int unsigned                         reps;
		bit                                  fixed;
		cldrm_pkg::status_t                  fixed_status;
		int unsigned                         fixed_count;
	} script_row_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	cldrm_req_if req_ch ();
	cldrm_rsp_if rsp_ch ();

	circular_list_deque_remove_matching_unit #(
		.CAPACITY(CAPACITY)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	// Shadow copy of the held entries, front first, and the words still owed by the block.
	logic signed [cldrm_pkg::DATA_W-1:0] list_image[$];
	rsp_word_t                           pending_words[$];

	int unsigned cycle_count      = 0;
	int unsigned error_count      = 0;
	int unsigned words_checked    = 0;
	int unsigned requests_seen[4] = '{0, 0, 0, 0};
	int unsigned peak_held        = 0;
	int unsigned full_drops       = 0;
	int unsigned removals_emptied = 0;
	int unsigned burst_left       = 0;
	int unsigned stall_mode       = STALL_NONE;
	int unsigned stall_window     = 0;

	logic signed [cldrm_pkg::DATA_W-1:0] value_pool[4];
	script_row_t                         script[SCRIPT_LEN];

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic rsp_word_t make_word(input cldrm_pkg::status_t s,
			input logic signed [cldrm_pkg::DATA_W-1:0] v,
			input int unsigned cnt, input int unsigned rem, input logic lst);
		rsp_word_t w;
		w.status        = s;
		w.entry_value   = v;
		w.entry_count   = cldrm_pkg::COUNT_W'(cnt);
		w.removed_count = cldrm_pkg::COUNT_W'(rem);
		w.last          = lst;
		return w;
	endfunction

	// Apply one request to the shadow list; queue its result words when asked to.
	function automatic void predict_list(input cldrm_pkg::req_t kind,
			input logic signed [cldrm_pkg::DATA_W-1:0] value, input bit queue_words);
		int unsigned                         held;
		int unsigned                         kept;
		logic signed [cldrm_pkg::DATA_W-1:0] survivors[$];
		rsp_word_t                           words[$];
		held = list_image.size();
		requests_seen[kind]++;
		if (kind == cldrm_pkg::REQ_APPEND || kind == cldrm_pkg::REQ_INSERT) begin
			if (held >= CAPACITY) begin
				words.push_back(make_word(cldrm_pkg::STAT_FULL, '0, held, 0, 1'b1));
				full_drops++;
			end else begin
				if (kind == cldrm_pkg::REQ_APPEND) begin
					list_image.push_back(value);
				end else begin
					list_image.push_front(value);
				end
				words.push_back(make_word(cldrm_pkg::STAT_OK, '0, held + 1, 0, 1'b1));
			end
		end else if (held == 0) begin
			words.push_back(make_word(cldrm_pkg::STAT_EMPTY, '0, 0, 0, 1'b1));
		end else if (kind == cldrm_pkg::REQ_REMOVE) begin
			foreach (list_image[i]) begin
				if (list_image[i] !== value) survivors.push_back(list_image[i]);
			end
			list_image = survivors;
			kept = survivors.size();
			if (kept == 0) removals_emptied++;
			words.push_back(make_word(cldrm_pkg::STAT_OK, '0, kept, held - kept, 1'b1));
		end else begin
			foreach (list_image[i]) begin
				words.push_back(make_word(cldrm_pkg::STAT_OK, list_image[i], held, 0,
					i == held - 1));
			end
		end
		if (list_image.size() > peak_held) peak_held = list_image.size();
		if (queue_words) begin
			foreach (words[i]) pending_words.push_back(words[i]);
		end
	endfunction

	// Present one request word, idling between bursts, and record its expected results
	// at the edge where it is taken.
	task automatic issue(input cldrm_pkg::req_t kind,
			input logic signed [cldrm_pkg::DATA_W-1:0] value, input bit fixed,
			input cldrm_pkg::status_t fixed_status, input int unsigned fixed_count);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				req_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) :
				$urandom_range(1, 8);
		end
		burst_left--;
		req_ch.valid      <= 1'b1;
		req_ch.req_type   <= kind;
		req_ch.item_value <= value;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		predict_list(kind, value, !fixed);
		if (fixed) pending_words.push_back(make_word(fixed_status, '0, fixed_count, 0, 1'b1));
	endtask

	// Pick a value: often one already held or from a small pool, so that removals match
	// and duplicates build up; otherwise any 32-bit value.
	function automatic logic signed [cldrm_pkg::DATA_W-1:0] pick_value(input bit for_removal);
		int unsigned sel;
		sel = $urandom_range(0, 9);
		if (for_removal && list_image.size() != 0 && sel < 6) begin
			return list_image[$urandom_range(0, list_image.size() - 1)];
		end
		if (sel < 7) return value_pool[$urandom_range(0, 3)];
		return $urandom;
	endfunction

	// Receiver stall pattern: windows of always ready, mostly ready, mostly stalled,
	// or alternating.
	always @(posedge clk) begin
		if (stall_window == 0) begin
			stall_mode   <= $urandom_range(STALL_NONE, STALL_TOGGLE);
			stall_window <= $urandom_range(10, 60);
		end else begin
			stall_window <= stall_window - 1;
		end
		case (stall_mode)
			STALL_NONE: begin
				rsp_ch.ready <= 1'b1;
			end
			STALL_LIGHT: begin
				rsp_ch.ready <= ($urandom_range(0, 3) != 0);
			end
			STALL_HEAVY: begin
				rsp_ch.ready <= ($urandom_range(0, 3) == 0);
			end
			default: begin
				rsp_ch.ready <= !rsp_ch.ready;
			end
		endcase
	end

	// Compare each taken result word with the oldest expected word.
	always @(posedge clk) begin
		rsp_word_t seen;
		rsp_word_t want;
		if (arst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
			seen.status        = rsp_ch.status;
			seen.entry_value   = rsp_ch.entry_value;
			seen.entry_count   = rsp_ch.entry_count;
			seen.removed_count = rsp_ch.removed_count;
			seen.last          = rsp_ch.last;
			words_checked++;
			if (pending_words.size() == 0) begin
				error_count++;
				if (error_count <= 10) begin
					$display("cycle %0d: unexpected word status=%0d value=%0d count=%0d",
						cycle_count, seen.status, seen.entry_value, seen.entry_count);
					$display("    removed=%0d last=%0b", seen.removed_count, seen.last);
				end
			end else begin
				want = pending_words.pop_front();
				if (seen.status !== want.status || seen.entry_value !== want.entry_value ||
						seen.entry_count !== want.entry_count ||
						seen.removed_count !== want.removed_count || seen.last !== want.last) begin
					error_count++;
					if (error_count <= 10) begin
						$display("cycle %0d: mismatch", cycle_count);
						$display("    expected status=%0d value=%0d count=%0d removed=%0d last=%0b",
							want.status, want.entry_value, want.entry_count,
							want.removed_count, want.last);
						$display("    got      status=%0d value=%0d count=%0d removed=%0d last=%0b",
							seen.status, seen.entry_value, seen.entry_count,
							seen.removed_count, seen.last);
					end
				end
			end
		end
	end

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles with %0d words outstanding", cycle_count,
				pending_words.size());
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Stimulus: reset, directed script, biased random traffic, then drain and report.
	initial begin
		cldrm_pkg::req_t kind;
		bit              filling;
		int unsigned     roll;
		req_ch.valid      = 1'b0;
		req_ch.req_type   = cldrm_pkg::REQ_APPEND;
		req_ch.item_value = '0;
		rsp_ch.ready      = 1'b0;

		value_pool[0] = '0;
		value_pool[1] = -1;
		value_pool[2] = $urandom;
		value_pool[3] = $urandom;

		// Empty-list requests, extreme values, removal of absent, single and repeated values,
		// a fill past capacity from both ends, and removal of every entry.
		script = '{
			'{cldrm_pkg::REQ_REMOVE, 32'sd0,         1, 1'b1, cldrm_pkg::STAT_EMPTY, 0},
			'{cldrm_pkg::REQ_DUMP,   32'sd0,         1, 1'b1, cldrm_pkg::STAT_EMPTY, 0},
			'{cldrm_pkg::REQ_APPEND, 32'sh7FFF_FFFF, 1, 1'b1, cldrm_pkg::STAT_OK,    1},
			'{cldrm_pkg::REQ_INSERT, 32'sh8000_0000, 1, 1'b1, cldrm_pkg::STAT_OK,    2},
			'{cldrm_pkg::REQ_APPEND, 32'shFFFF_FFFF, 1, 1'b1, cldrm_pkg::STAT_OK,    3},
			'{cldrm_pkg::REQ_DUMP,   32'sd0,         1, 1'b0, cldrm_pkg::STAT_OK,    0},
			'{cldrm_pkg::REQ_REMOVE, 32'sd5,         1, 1'b0, cldrm_pkg::STAT_OK,    0},
			'{cldrm_pkg::REQ_REMOVE, 32'sh7FFF_FFFF, 1, 1'b0, cldrm_pkg::STAT_OK,    0},
			'{cldrm_pkg::REQ_REMOVE, 32'sh8000_0000, 1, 1'b0, cldrm_pkg::STAT_OK,    0},
			'{cldrm_pkg::REQ_REMOVE, 32'shFFFF_FFFF, 1, 1'b0, cldrm_pkg::STAT_OK,    0},
			'{cldrm_pkg::REQ_APPEND, 32'sd3,         1, 1'b1, cldrm_pkg::STAT_OK,    1},
			'{cldrm_pkg::REQ_APPEND, 32'sd4,         1, 1'b1, cldrm_pkg::STAT_OK,    2},
			'{cldrm_pkg::REQ_APPEND, 32'sd3,         1, 1'b1, cldrm_pkg::STAT_OK,    3},
			'{cldrm_pkg::REQ_INSERT, 32'sd3,         1, 1'b1, cldrm_pkg::STAT_OK,    4},
			'{cldrm_pkg::REQ_REMOVE, 32'sd3,         1, 1'b0, cldrm_pkg::STAT_OK,    0},
			'{cldrm_pkg::REQ_DUMP,   32'sd0,         1, 1'b0, cldrm_pkg::STAT_OK,    0},
			'{cldrm_pkg::REQ_REMOVE, 32'sd4,         1, 1'b0, cldrm_pkg::STAT_OK,    0},
			'{cldrm_pkg::REQ_APPEND, 32'sh5A5A_5A5A, 8, 1'b0, cldrm_pkg::STAT_OK,    0},
			'{cldrm_pkg::REQ_INSERT, 32'sh5A5A_5A5A, 8, 1'b0, cldrm_pkg::STAT_OK,    0},
			'{cldrm_pkg::REQ_INSERT, 32'sd1,         1, 1'b1, cldrm_pkg::STAT_FULL,  CAPACITY},
			'{cldrm_pkg::REQ_APPEND, 32'sd1,         1, 1'b1, cldrm_pkg::STAT_FULL,  CAPACITY},
			'{cldrm_pkg::REQ_DUMP,   32'sd0,         1, 1'b0, cldrm_pkg::STAT_OK,    0},
			'{cldrm_pkg::REQ_REMOVE, 32'sh5A5A_5A5A, 1, 1'b0, cldrm_pkg::STAT_OK,    0},
			'{cldrm_pkg::REQ_DUMP,   32'sd0,         1, 1'b1, cldrm_pkg::STAT_EMPTY, 0}
		};

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[r]) begin
			for (int n = 0; n < script[r].reps; n++) begin
				issue(script[r].kind, script[r].value, script[r].fixed, script[r].fixed_status,
					script[r].fixed_count);
			end
		end

		// Random traffic alternates between phases that tend to fill the list and phases
		// that tend to drain it, so both full and empty lists recur.
		filling = 1'b1;
		for (int unsigned k = 0; k < RANDOM_ITEMS; k++) begin
			if (k % 30 == 0) filling = !filling;
			if (k == RANDOM_ITEMS / 2) begin
				req_ch.valid <= 1'b0;
				do @(posedge clk); while (pending_words.size() != 0);
			end
			roll = $urandom_range(0, 99);
			if (filling) begin
				kind = (roll < 40) ? cldrm_pkg::REQ_APPEND : (roll < 80) ? cldrm_pkg::REQ_INSERT :
					(roll < 90) ? cldrm_pkg::REQ_REMOVE : cldrm_pkg::REQ_DUMP;
			end else begin
				kind = (roll < 15) ? cldrm_pkg::REQ_APPEND : (roll < 30) ? cldrm_pkg::REQ_INSERT :
					(roll < 80) ? cldrm_pkg::REQ_REMOVE : cldrm_pkg::REQ_DUMP;
			end
			issue(kind, pick_value(kind == cldrm_pkg::REQ_REMOVE), 1'b0, cldrm_pkg::STAT_OK, 0);
		end

		req_ch.valid <= 1'b0;
		do @(posedge clk); while (pending_words.size() != 0);
		repeat (CAPACITY + 8) @(posedge clk);

		$display("Ran %0d appends, %0d front inserts, %0d removals, %0d dumps; %0d words checked.",
			requests_seen[cldrm_pkg::REQ_APPEND], requests_seen[cldrm_pkg::REQ_INSERT],
			requests_seen[cldrm_pkg::REQ_REMOVE], requests_seen[cldrm_pkg::REQ_DUMP],
			words_checked);
		$display("Peak fill %0d of %0d, %0d inserts refused as full, %0d removals emptied it.",
			peak_held, CAPACITY, full_drops, removals_emptied);
		if (error_count == 0 && pending_words.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("%0d mismatches, %0d words never arrived", error_count, pending_words.size());
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
